/* sv/i2a_pkg.sv */
package i2a_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W = 8;
  localparam int STEP_BITS = 4;
  localparam int DIGIT_DEPTH = 32;
  localparam int SP_W = $clog2(DIGIT_DEPTH + 1);
  localparam int IDX_W = $clog2(DIGIT_DEPTH);

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] SIGNED_RADIX = 6'd10;

  localparam logic [0:0] REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'h57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef logic [RADIX_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0] char_t;

  function automatic char_t digit_char(input digit_t dgt);
    if (dgt < 6'd10) begin
      return CHAR_ZERO + CHAR_W'(dgt);
    end
    return CHAR_ALPHA_OFS + CHAR_W'(dgt);
  endfunction

endpackage

/* sv/i2a_in_if.sv */
interface i2a_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        signed_mode;

  modport source (output valid, output value, output signed_mode, input ready);
  modport sink (input valid, input value, input signed_mode, output ready);
endinterface

/* sv/i2a_out_if.sv */
interface i2a_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

/* sv/integer_to_ascii_radix_core.sv */
// Each digit costs one division by the radix, run least significant digit first; the characters
// are then emitted most significant digit first while the output is taken.
// One number at a time: a new number is accepted only in idle, after its last character is issued;
// the shared divide-by-radix unit serves every digit of it.
// Reset (rst, synchronous, active high) sets radix to 10 and returns the sequencer to idle.
module integer_to_ascii_radix_core
  import i2a_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  i2a_in_if.sink      in_ch,
  i2a_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] remaining;
  logic [VALUE_WIDTH-1:0] v_in;
  logic [RADIX_W-1:0]     base;
  logic [RADIX_W-1:0]     radix_eff;
  logic                   neg_pending;
  digit_t                 stack [DIGIT_DEPTH];
  logic [SP_W-1:0]        sp;
  logic [SP_W-1:0]        sp_m1;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_q;
  digit_t                 div_r;
  logic                   out_free;

  i2a_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .radix_eff (radix_eff)
  );

  i2a_div #(.W(VALUE_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_START),
    .dividend  (remaining),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign v_in = VALUE_WIDTH'(in_ch.value);
  assign in_ch.ready = (state == S_IDLE);
  assign out_free = !out_ch.valid || out_ch.ready;
  assign sp_m1 = sp - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      neg_pending <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && !(state == S_EMIT && out_free)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sp <= '0;
            if (in_ch.signed_mode) begin
              base <= SIGNED_RADIX;
              neg_pending <= v_in[VALUE_WIDTH-1];
              remaining <= v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;
            end else begin
              base <= radix_eff;
              neg_pending <= 1'b0;
              remaining <= v_in;
            end
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            stack[sp[IDX_W-1:0]] <= div_r;
            sp <= sp + 1'b1;
            remaining <= div_q;
            state <= (div_q == '0) ? S_EMIT : S_START;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            if (neg_pending) begin
              out_ch.character <= CHAR_MINUS;
              out_ch.last <= 1'b0;
              neg_pending <= 1'b0;
            end else begin
              out_ch.character <= digit_char(stack[sp_m1[IDX_W-1:0]]);
              out_ch.last <= (sp == SP_W'(1));
              sp <= sp_m1;
              if (sp == SP_W'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/i2a_cfg.sv */
module i2a_cfg
  import i2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [RADIX_W-1:0]   radix_eff
);

  logic [RADIX_W-1:0] radix;
  logic               sel_radix;

  assign pready = 1'b1;
  assign sel_radix = (paddr[2] == REG_RADIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && sel_radix) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_radix) begin
      prdata = 32'(radix);
    end
  end

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

endmodule

/* sv/i2a_div.sv */
module i2a_div
  import i2a_pkg::*;
#(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic               done,
  output logic [W-1:0]       quotient,
  output logic [RADIX_W-1:0] remainder
);

  localparam int PW = ((W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int NSTEP = PW / STEP_BITS;
  localparam int CW = $clog2(NSTEP + 1);

  logic [PW-1:0]      work;
  logic [PW-1:0]      work_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;
  logic [RADIX_W-1:0] divs;
  logic [CW-1:0]      cnt;
  logic               busy;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [RADIX_W:0] t;
    work_next = work;
    rem_next = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {rem_next, work_next[PW-1]};
      work_next = {work_next[PW-2:0], 1'b0};
      if (t >= {1'b0, divs}) begin
        rem_next = RADIX_W'(t - {1'b0, divs});
        work_next[0] = 1'b1;
      end else begin
        rem_next = t[RADIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= PW'(dividend);
        rem <= '0;
        divs <= divisor;
        cnt <= CW'(NSTEP);
        busy <= 1'b1;
      end else if (busy) begin
        work <= work_next;
        rem <= rem_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work[W-1:0];
  assign remainder = rem;

endmodule
